// File: src/tkpc_pkg.sv
// Shared types, register codes, reset values and event codes of the three-key press classifier.
package tkpc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 8;
    localparam int PRESS_CLEAR_AT      = 2;
    localparam int CFG_INDEX_WIDTH     = 3;
    localparam int CFG_DATA_WIDTH      = 8;
    localparam int TICK_WIDTH          = 8;
    localparam int SHORT_WIDTH         = 4;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_LONG_TICKS,
        CFG_REPEAT_TICKS,
        CFG_HOLD_TICKS,
        CFG_SHORT_MAX_TICKS,
        CFG_MIN_PRESS_TICKS,
        CFG_RELEASE_TICKS
    } cfg_index_t;

    typedef logic [1:0] key_event_t;
    localparam key_event_t EV_NONE  = 2'd0;
    localparam key_event_t EV_SHORT = 2'd1;
    localparam key_event_t EV_LONG  = 2'd2;

    typedef struct packed {
        logic [TICK_WIDTH-1:0]  long_ticks;
        logic [TICK_WIDTH-1:0]  repeat_ticks;
        logic [TICK_WIDTH-1:0]  hold_ticks;
        logic [TICK_WIDTH-1:0]  short_max_ticks;
        logic [SHORT_WIDTH-1:0] min_press_ticks;
        logic [SHORT_WIDTH-1:0] release_ticks;
    } tkpc_cfg_t;

    localparam logic [TICK_WIDTH-1:0]  LONG_TICKS_RESET      = 8'd30;
    localparam logic [TICK_WIDTH-1:0]  REPEAT_TICKS_RESET    = 8'd30;
    localparam logic [TICK_WIDTH-1:0]  HOLD_TICKS_RESET      = 8'd200;
    localparam logic [TICK_WIDTH-1:0]  SHORT_MAX_TICKS_RESET = 8'd50;
    localparam logic [SHORT_WIDTH-1:0] MIN_PRESS_TICKS_RESET = 4'd3;
    localparam logic [SHORT_WIDTH-1:0] RELEASE_TICKS_RESET   = 4'd2;

    typedef struct packed {
        logic key_a_level;
        logic key_b_level;
        logic key_c_level;
        logic charging;
        logic battery_low;
    } tkpc_tick_t;

endpackage

// File: src/tkpc_hold_key.sv
// Press counter and short/hold classifier for one of the hold-style keys.
module tkpc_hold_key import tkpc_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic       pressed,
    input  tkpc_cfg_t  cfg,
    output key_event_t key_event
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CLEAR_AT  = COUNT_WIDTH'(PRESS_CLEAR_AT);

    logic [COUNT_WIDTH-1:0] press_count_reg, press_count_next;
    logic [SHORT_WIDTH-1:0] release_count_reg, release_count_next;
    logic [COUNT_WIDTH-1:0] hold_lim, short_lim, min_lim, press_inc;

    always_comb begin
        hold_lim           = COUNT_WIDTH'(cfg.hold_ticks);
        short_lim          = COUNT_WIDTH'(cfg.short_max_ticks);
        min_lim            = COUNT_WIDTH'(cfg.min_press_ticks);
        press_inc          = press_count_reg + COUNT_WIDTH'(1);
        press_count_next   = press_count_reg;
        release_count_next = release_count_reg;
        key_event          = EV_NONE;
        if (pressed) begin
            if (press_count_reg < hold_lim) begin
                press_count_next = press_inc;
                // The hold event fires once; the count then parks above the limit.
                if (press_inc == hold_lim) begin
                    key_event = EV_LONG;
                    if (press_inc < COUNT_MAX) begin
                        press_count_next = press_inc + COUNT_WIDTH'(1);
                    end
                end
            end
            if (press_count_next >= CLEAR_AT) begin
                release_count_next = '0;
            end
        end else if (release_count_reg < cfg.release_ticks) begin
            release_count_next = release_count_reg + SHORT_WIDTH'(1);
        end else begin
            if (press_count_reg >= min_lim && press_count_reg <= short_lim) begin
                key_event = EV_SHORT;
            end
            press_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_count_reg   <= '0;
            release_count_reg <= '0;
        end else if (step) begin
            press_count_reg   <= press_count_next;
            release_count_reg <= release_count_next;
        end
    end

endmodule

// File: src/three_key_press_classifier.sv
// Top level of the three-key press classifier: input register, key logic and result register.
//
// The block takes one tick request per cycle on the s_ channel while results drain, each
// carrying the three active-low key levels and the charging and low-battery flags, and
// returns exactly one result request per tick on the m_ channel. A tick is held in an
// input register, classified by short combinational logic that updates the small per-key
// counters, and the result lands in an output register; a new tick can be accepted every
// cycle while results drain, and the sustained rate is one tick per cycle, set by the
// single counter update per key per tick. While a result waits downstream, the input register
// takes at most one more tick and then holds s_ready low. Key A reports a short press on a
// qualified release and a long event when its press count reaches long_ticks, repeating
// every repeat_ticks while held. Keys B and C report a short press on a qualified release and
// a single hold event at hold_ticks. Charging suppresses every event; low battery replaces
// any event with a one-tick warning. Configuration registers are written through the cfg_
// channel, which is always ready, and must only be written while no tick is in flight.
module three_key_press_classifier import tkpc_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration write channel.
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    // Tick input channel.
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_key_a_level,
    input  logic                       s_key_b_level,
    input  logic                       s_key_c_level,
    input  logic                       s_charging,
    input  logic                       s_battery_low,
    // Result channel.
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_key_a_event,
    output logic [1:0]                 m_key_b_event,
    output logic [1:0]                 m_key_c_event,
    output logic                       m_low_battery_warn
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CLEAR_AT  = COUNT_WIDTH'(PRESS_CLEAR_AT);

    // Configuration registers.
    tkpc_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LONG_TICKS:      cfg_next.long_ticks      = cfg_data;
                CFG_REPEAT_TICKS:    cfg_next.repeat_ticks    = cfg_data;
                CFG_HOLD_TICKS:      cfg_next.hold_ticks      = cfg_data;
                CFG_SHORT_MAX_TICKS: cfg_next.short_max_ticks = cfg_data;
                CFG_MIN_PRESS_TICKS: cfg_next.min_press_ticks = cfg_data[SHORT_WIDTH-1:0];
                CFG_RELEASE_TICKS:   cfg_next.release_ticks   = cfg_data[SHORT_WIDTH-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_ticks      <= LONG_TICKS_RESET;
            cfg_reg.repeat_ticks    <= REPEAT_TICKS_RESET;
            cfg_reg.hold_ticks      <= HOLD_TICKS_RESET;
            cfg_reg.short_max_ticks <= SHORT_MAX_TICKS_RESET;
            cfg_reg.min_press_ticks <= MIN_PRESS_TICKS_RESET;
            cfg_reg.release_ticks   <= RELEASE_TICKS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register. The tick moves on whenever the result register is empty or being
    // drained, so an empty input register can still take a tick while a result waits.
    tkpc_tick_t tick_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tick_reg <= '{key_a_level: s_key_a_level, key_b_level: s_key_b_level,
                          key_c_level: s_key_c_level, charging: s_charging,
                          battery_low: s_battery_low};
        end
    end

    // Key A: short press, long press and auto-repeat.
    logic [COUNT_WIDTH-1:0] a_press_count_reg, a_press_count_next;
    logic [COUNT_WIDTH-1:0] a_repeat_count_reg, a_repeat_count_next;
    logic [SHORT_WIDTH-1:0] a_release_count_reg, a_release_count_next;
    logic [COUNT_WIDTH-1:0] a_long_lim, a_repeat_lim, a_min_lim, a_press_inc, a_repeat_inc;
    key_event_t             a_event;

    always_comb begin
        a_long_lim           = COUNT_WIDTH'(cfg_reg.long_ticks);
        a_repeat_lim         = COUNT_WIDTH'(cfg_reg.repeat_ticks);
        a_min_lim            = COUNT_WIDTH'(cfg_reg.min_press_ticks);
        a_press_inc          = a_press_count_reg + COUNT_WIDTH'(1);
        a_repeat_inc         = a_repeat_count_reg;
        a_press_count_next   = a_press_count_reg;
        a_repeat_count_next  = a_repeat_count_reg;
        a_release_count_next = a_release_count_reg;
        a_event              = EV_NONE;
        if (!tick_reg.key_a_level) begin
            if (a_press_count_reg <= a_long_lim && a_press_count_reg < COUNT_MAX) begin
                // Still counting toward the first long event.
                a_press_count_next = a_press_inc;
                if (a_press_inc == a_long_lim) begin
                    a_event = EV_LONG;
                end
            end else begin
                // Past the long threshold: the repeat counter paces further long events.
                if (a_repeat_count_reg < COUNT_MAX) begin
                    a_repeat_inc = a_repeat_count_reg + COUNT_WIDTH'(1);
                end
                a_repeat_count_next = a_repeat_inc;
                if (a_repeat_inc >= a_repeat_lim) begin
                    a_repeat_count_next = '0;
                    a_event             = EV_LONG;
                end
            end
            if (a_press_count_next >= CLEAR_AT) begin
                a_release_count_next = '0;
            end
        end else if (a_release_count_reg < cfg_reg.release_ticks) begin
            a_release_count_next = a_release_count_reg + SHORT_WIDTH'(1);
        end else begin
            // Qualified release: a press inside the short window reports a short event.
            if (a_press_count_reg >= a_min_lim && a_press_count_reg <= a_long_lim) begin
                a_event = EV_SHORT;
            end
            a_press_count_next  = '0;
            a_repeat_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_press_count_reg   <= '0;
            a_repeat_count_reg  <= '0;
            a_release_count_reg <= '0;
        end else if (advance) begin
            a_press_count_reg   <= a_press_count_next;
            a_repeat_count_reg  <= a_repeat_count_next;
            a_release_count_reg <= a_release_count_next;
        end
    end

    // Keys B and C each use their own instance of the short/hold classifier.
    key_event_t b_event, c_event;

    tkpc_hold_key #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_key_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .pressed   (!tick_reg.key_b_level),
        .cfg       (cfg_reg),
        .key_event (b_event)
    );

    tkpc_hold_key #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_key_c (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .pressed   (!tick_reg.key_c_level),
        .cfg       (cfg_reg),
        .key_event (c_event)
    );

    // Power gating of events: charging wins over low battery.
    key_event_t a_final, b_final, c_final;
    logic       warn_final;
    logic       any_event;

    always_comb begin
        any_event  = (a_event != EV_NONE) || (b_event != EV_NONE) || (c_event != EV_NONE);
        a_final    = a_event;
        b_final    = b_event;
        c_final    = c_event;
        warn_final = 1'b0;
        if (tick_reg.charging || tick_reg.battery_low) begin
            a_final = EV_NONE;
            b_final = EV_NONE;
            c_final = EV_NONE;
        end
        if (!tick_reg.charging && tick_reg.battery_low && any_event) begin
            warn_final = 1'b1;
        end
    end

    // Result register.
    key_event_t a_out_reg, b_out_reg, c_out_reg;
    logic       warn_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_out_reg    <= a_final;
            b_out_reg    <= b_final;
            c_out_reg    <= c_final;
            warn_out_reg <= warn_final;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_key_a_event      = a_out_reg;
    assign m_key_b_event      = b_out_reg;
    assign m_key_c_event      = c_out_reg;
    assign m_low_battery_warn = warn_out_reg;

    // A warning never travels together with an event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_low_battery_warn |->
            m_key_a_event == EV_NONE && m_key_b_event == EV_NONE && m_key_c_event == EV_NONE)
        else $error("low battery warning reported together with a key event");

    // No result is presented in the cycle after reset.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // A tick that cannot move on stays in the input register unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(tick_reg))
        else $error("stalled tick lost from the input register");

    // A short event on key A always clears its press and repeat counts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && a_event == EV_SHORT |=> a_press_count_reg == '0 && a_repeat_count_reg == '0)
        else $error("key A counters not cleared after a short press");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the three-key press classifier: directed ticks, then random key sequences.
module testbench;
    import tkpc_pkg::*;

    // Register settings that the run loads between phases. SET_KEEP leaves the current
    // settings alone, and SET_RAND is drawn fresh each time it is loaded.
    typedef enum logic [2:0] {
        SET_KEEP,
        SET_RESET,
        SET_TIGHT,
        SET_ZERO,
        SET_LOW,
        SET_HIGH,
        SET_MAX,
        SET_RAND
    } setting_t;

    // One result request, laid out in port order.
    typedef struct packed {
        key_event_t a_event;
        key_event_t b_event;
        key_event_t c_event;
        logic       warn;
    } key_result_t;

    // One row of the directed stimulus. When typed is set, want is the result that the
    // row must give. Otherwise the predictor decides.
    typedef struct packed {
        setting_t    setting;
        tkpc_tick_t  tick;
        logic        typed;
        key_result_t want;
    } tick_row_t;

    localparam logic [TICK_WIDTH-1:0] COUNT_TOP = 8'hFF;
    localparam int SHORT_PHASE_TICKS = 150;
    localparam int LONG_PHASE_TICKS  = 300;
    localparam int PHASE_COUNT       = 8;
    localparam int DIRECTED_ROWS     = 25;

    localparam key_result_t NO_EVENTS = '0;
    localparam key_result_t ALL_HELD  = {EV_LONG, EV_LONG, EV_LONG, 1'b0};

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_key_a_level;
    logic                       s_key_b_level;
    logic                       s_key_c_level;
    logic                       s_charging;
    logic                       s_battery_low;
    logic                       m_valid;
    logic                       m_ready;
    logic [1:0]                 m_key_a_event;
    logic [1:0]                 m_key_b_event;
    logic [1:0]                 m_key_c_event;
    logic                       m_low_battery_warn;

    // The predictor's copy of the registers and of the per-key counters. Index 0 of the
    // hold arrays is key B and index 1 is key C.
    tkpc_cfg_t             model_cfg;
    logic [TICK_WIDTH-1:0] a_press;
    logic [TICK_WIDTH-1:0] a_repeat;
    logic [3:0]            a_release;
    logic [TICK_WIDTH-1:0] hold_press [0:1];
    logic [3:0]            hold_release [0:1];

    // Results that accepted ticks must still produce, oldest first.
    key_result_t pending_results [$];

    tkpc_cfg_t settings [0:7];
    tick_row_t directed_rows [0:DIRECTED_ROWS-1];

    // Random key sequencer: current level of each key and the ticks left at that level.
    logic key_level [0:2];
    int   key_left [0:2];

    int tx_idle_pct;
    int rx_stall_pct;
    int mismatches;
    int results_checked;
    int ticks_sent;
    int settings_loaded;
    int short_events;
    int long_events;
    int warnings;

    three_key_press_classifier dut (.*);

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // The whole run must fit well inside this time, even with both sides stalling hard.
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Key A: counts up while held, fires the long event at long_ticks and then repeats
    // every repeat_ticks. A qualified release inside the short window gives a short event.
    function automatic key_event_t step_key_a(logic pressed);
        key_event_t ev;
        ev = EV_NONE;
        if (pressed) begin
            if (a_press <= model_cfg.long_ticks && a_press != COUNT_TOP) begin
                a_press = a_press + 8'd1;
                if (a_press == model_cfg.long_ticks) ev = EV_LONG;
            end else begin
                if (a_repeat != COUNT_TOP) a_repeat = a_repeat + 8'd1;
                if (a_repeat >= model_cfg.repeat_ticks) begin
                    a_repeat = '0;
                    ev = EV_LONG;
                end
            end
            if (a_press >= PRESS_CLEAR_AT) a_release = '0;
        end else if (a_release < model_cfg.release_ticks) begin
            a_release = a_release + 4'd1;
        end else begin
            if (a_press >= model_cfg.min_press_ticks && a_press <= model_cfg.long_ticks) begin
                ev = EV_SHORT;
            end
            a_press = '0;
            a_repeat = '0;
        end
        return ev;
    endfunction

    // Keys B and C: one hold event when the count first reaches hold_ticks, after which the
    // count parks one above it so that the release that follows is not a short press.
    function automatic key_event_t step_hold_key(int k, logic pressed);
        key_event_t ev;
        ev = EV_NONE;
        if (pressed) begin
            if (hold_press[k] < model_cfg.hold_ticks) begin
                hold_press[k] = hold_press[k] + 8'd1;
                if (hold_press[k] == model_cfg.hold_ticks) begin
                    ev = EV_LONG;
                    if (hold_press[k] != COUNT_TOP) hold_press[k] = hold_press[k] + 8'd1;
                end
            end
            if (hold_press[k] >= PRESS_CLEAR_AT) hold_release[k] = '0;
        end else if (hold_release[k] < model_cfg.release_ticks) begin
            hold_release[k] = hold_release[k] + 4'd1;
        end else begin
            if (hold_press[k] >= model_cfg.min_press_ticks &&
                hold_press[k] <= model_cfg.short_max_ticks) begin
                ev = EV_SHORT;
            end
            hold_press[k] = '0;
        end
        return ev;
    endfunction

    // All three keys advance on every tick. Charging then drops every event, and low
    // battery turns any surviving event into a single warning.
    function automatic key_result_t classify_tick(tkpc_tick_t t);
        key_result_t r;
        r.a_event = step_key_a(!t.key_a_level);
        r.b_event = step_hold_key(0, !t.key_b_level);
        r.c_event = step_hold_key(1, !t.key_c_level);
        r.warn = 1'b0;
        if (t.charging) begin
            r = NO_EVENTS;
        end else if (t.battery_low && (r.a_event != EV_NONE || r.b_event != EV_NONE ||
                                       r.c_event != EV_NONE)) begin
            r = NO_EVENTS;
            r.warn = 1'b1;
        end
        return r;
    endfunction

    function automatic tick_row_t row(setting_t setting, logic [4:0] levels, logic typed,
                                      key_result_t want);
        tick_row_t r;
        r.setting = setting;
        r.tick = levels;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    // Mostly short windows so that thresholds are reached often, now and then the full range.
    function automatic tkpc_cfg_t random_setting();
        tkpc_cfg_t c;
        int top;
        top = ($urandom_range(0, 3) == 0) ? 254 : 40;
        c.long_ticks = 8'($urandom_range(3, top));
        c.repeat_ticks = 8'($urandom_range(1, top));
        c.hold_ticks = 8'($urandom_range(3, top));
        c.short_max_ticks = 8'($urandom_range(3, top));
        c.min_press_ticks = 4'($urandom_range(1, 15));
        c.release_ticks = 4'($urandom_range(1, 6));
        return c;
    endfunction

    // Press lengths aim at the interesting counts: bounces, the short window, just around
    // the long or hold threshold, several repeats, and now and then anything at all.
    function automatic int press_length(int k);
        int thr;
        int window_top;
        int len;
        thr = (k == 0) ? int'(model_cfg.long_ticks) : int'(model_cfg.hold_ticks);
        window_top = (k == 0) ? int'(model_cfg.long_ticks) : int'(model_cfg.short_max_ticks);
        case ($urandom_range(0, 9))
            0: len = 1;
            1, 2, 3, 4: len = $urandom_range(model_cfg.min_press_ticks, window_top + 1);
            5, 6: len = $urandom_range((thr > 1) ? thr - 1 : 1, thr + 2);
            7, 8: len = thr + $urandom_range(0, 3) * model_cfg.repeat_ticks + $urandom_range(0, 20);
            default: len = $urandom_range(1, 300);
        endcase
        return (len < 1) ? 1 : len;
    endfunction

    // Most releases last long enough to qualify. The rest are bounces that mostly end too early.
    function automatic int release_length();
        if ($urandom_range(0, 4) == 0) return $urandom_range(1, model_cfg.release_ticks + 1);
        return $urandom_range(model_cfg.release_ticks + 1, model_cfg.release_ticks + 6);
    endfunction

    function automatic tkpc_tick_t next_random_tick();
        tkpc_tick_t t;
        logic [2:0] lv;
        int k;
        for (k = 0; k < 3; k++) begin
            if (key_left[k] == 0) begin
                key_level[k] = !key_level[k];
                key_left[k] = key_level[k] ? release_length() : press_length(k);
            end
            key_left[k]--;
            lv[k] = key_level[k];
        end
        // A one-tick glitch on a random key, outside of the planned sequence.
        if ($urandom_range(0, 24) == 0) begin
            k = $urandom_range(0, 2);
            lv[k] = !lv[k];
        end
        t.key_a_level = lv[0];
        t.key_b_level = lv[1];
        t.key_c_level = lv[2];
        t.charging = ($urandom_range(0, 19) == 0);
        t.battery_low = ($urandom_range(0, 7) == 0);
        return t;
    endfunction

    task automatic report_mismatch(string field, logic [1:0] got, logic [1:0] want);
        $display("mismatch at result %0d: %s is %0d, expected %0d",
                 results_checked, field, got, want);
        mismatches++;
    endtask

    // Sends one tick request. The sender may first idle with valid low, then raises valid
    // at a falling edge and holds it until the rising edge that accepts the request.
    task automatic send_tick(tkpc_tick_t t, logic typed, key_result_t want);
        key_result_t predicted;
        while ($urandom_range(1, 100) <= tx_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_key_a_level <= t.key_a_level;
        s_key_b_level <= t.key_b_level;
        s_key_c_level <= t.key_c_level;
        s_charging <= t.charging;
        s_battery_low <= t.battery_low;
        do @(posedge aclk); while (!s_ready);
        predicted = classify_tick(t);
        pending_results.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    // Stops sending and waits until every pending result has come back.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LONG_TICKS:      model_cfg.long_ticks = value;
            CFG_REPEAT_TICKS:    model_cfg.repeat_ticks = value;
            CFG_HOLD_TICKS:      model_cfg.hold_ticks = value;
            CFG_SHORT_MAX_TICKS: model_cfg.short_max_ticks = value;
            CFG_MIN_PRESS_TICKS: model_cfg.min_press_ticks = value[SHORT_WIDTH-1:0];
            CFG_RELEASE_TICKS:   model_cfg.release_ticks = value[SHORT_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // Writes all six registers while the block is idle.
    task automatic load_settings(setting_t sel);
        tkpc_cfg_t c;
        if (sel == SET_RAND) settings[SET_RAND] = random_setting();
        c = settings[sel];
        wait_idle();
        write_reg(CFG_LONG_TICKS, c.long_ticks);
        write_reg(CFG_REPEAT_TICKS, c.repeat_ticks);
        write_reg(CFG_HOLD_TICKS, c.hold_ticks);
        write_reg(CFG_SHORT_MAX_TICKS, c.short_max_ticks);
        write_reg(CFG_MIN_PRESS_TICKS, 8'(c.min_press_ticks));
        write_reg(CFG_RELEASE_TICKS, 8'(c.release_ticks));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // The receiver decides at each falling edge whether it takes a result at the next
    // rising edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(1, 100) > rx_stall_pct);
    end

    // Every accepted result is compared field by field with the oldest pending one.
    always @(posedge aclk) begin : check_results
        key_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no tick pending", 2'd0, 2'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_key_a_event !== want.a_event) begin
                    report_mismatch("key_a_event", m_key_a_event, want.a_event);
                end
                if (m_key_b_event !== want.b_event) begin
                    report_mismatch("key_b_event", m_key_b_event, want.b_event);
                end
                if (m_key_c_event !== want.c_event) begin
                    report_mismatch("key_c_event", m_key_c_event, want.c_event);
                end
                if (m_low_battery_warn !== want.warn) begin
                    report_mismatch("low_battery_warn", {1'b0, m_low_battery_warn},
                                    {1'b0, want.warn});
                end
                results_checked++;
                short_events += int'(want.a_event == EV_SHORT) + int'(want.b_event == EV_SHORT) +
                                int'(want.c_event == EV_SHORT);
                long_events += int'(want.a_event == EV_LONG) + int'(want.b_event == EV_LONG) +
                               int'(want.c_event == EV_LONG);
                warnings += int'(want.warn);
            end
        end
    end

    initial begin : stimulus
        setting_t phase_order [0:PHASE_COUNT-1];
        int phase_ticks [0:PHASE_COUNT-1];
        int random_total;
        int random_done;
        int i;
        int n;

        // Every input of the block is known from time zero.
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_key_a_level = 1'b1;
        s_key_b_level = 1'b1;
        s_key_c_level = 1'b1;
        s_charging = 1'b0;
        s_battery_low = 1'b0;
        m_ready = 1'b0;

        // Register settings, in package field order: long, repeat, hold, short_max,
        // min_press, release. The zero and counter-top settings reach the corner cases
        // where the first event never fires or fires at the very last count.
        settings[SET_KEEP]  = {LONG_TICKS_RESET, REPEAT_TICKS_RESET, HOLD_TICKS_RESET,
                               SHORT_MAX_TICKS_RESET, MIN_PRESS_TICKS_RESET, RELEASE_TICKS_RESET};
        settings[SET_RESET] = settings[SET_KEEP];
        settings[SET_TIGHT] = {8'd3, 8'd2, 8'd3, 8'd4, 4'd2, 4'd1};
        settings[SET_ZERO]  = {8'd0, 8'd0, 8'd0, 8'd3, 4'd1, 4'd0};
        settings[SET_LOW]   = {8'd3, 8'd1, 8'd3, 8'd3, 4'd1, 4'd1};
        settings[SET_HIGH]  = {8'd254, 8'd255, 8'd254, 8'd254, 4'd15, 4'd15};
        settings[SET_MAX]   = {8'd255, 8'd255, 8'd255, 8'd255, 4'd15, 4'd15};
        settings[SET_RAND]  = settings[SET_KEEP];

        // The predictor starts from the reset state of the block.
        model_cfg = settings[SET_RESET];
        a_press = '0;
        a_repeat = '0;
        a_release = '0;
        for (i = 0; i < 2; i++) begin
            hold_press[i] = '0;
            hold_release[i] = '0;
        end
        for (i = 0; i < 3; i++) begin
            key_level[i] = 1'b1;
            key_left[i] = 0;
        end
        mismatches = 0;
        results_checked = 0;
        ticks_sent = 0;
        settings_loaded = 0;
        short_events = 0;
        long_events = 0;
        warnings = 0;

        // Directed ticks, written as {key A, key B, key C, charging, battery_low} with the
        // keys active low. The first rows run on the reset values of the registers.
        directed_rows = '{
            row(SET_KEEP,  5'b11100, 1'b1, NO_EVENTS),  // nothing pressed since reset
            row(SET_KEEP,  5'b00010, 1'b1, NO_EVENTS),  // charging drops everything
            row(SET_KEEP,  5'b00011, 1'b1, NO_EVENTS),  // charging beats low battery
            row(SET_KEEP,  5'b11100, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b11100, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b11100, 1'b0, NO_EVENTS),  // press too short to count
            row(SET_TIGHT, 5'b00000, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b00000, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b00000, 1'b1, ALL_HELD),   // long and hold thresholds reached
            row(SET_KEEP,  5'b00000, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b00000, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b00000, 1'b0, NO_EVENTS),  // first repeat on key A
            row(SET_KEEP,  5'b00001, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b00001, 1'b0, NO_EVENTS),  // repeat swallowed by low battery
            row(SET_KEEP,  5'b11100, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b11100, 1'b0, NO_EVENTS),  // release after hold, inside window
            row(SET_KEEP,  5'b01100, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b01100, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b11100, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b11100, 1'b0, NO_EVENTS),  // short press on key A
            row(SET_ZERO,  5'b00000, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b00000, 1'b0, NO_EVENTS),  // zero repeat fires every tick
            row(SET_KEEP,  5'b10100, 1'b0, NO_EVENTS),  // zero release qualifies at once
            row(SET_KEEP,  5'b11000, 1'b0, NO_EVENTS),
            row(SET_KEEP,  5'b11101, 1'b0, NO_EVENTS)
        };

        // Random phases, each under its own register settings. The settings at the top of
        // the count range get longer phases so that their thresholds are actually reached.
        phase_order = '{SET_RESET, SET_LOW, SET_HIGH, SET_ZERO, SET_MAX, SET_RAND, SET_TIGHT,
                        SET_RAND};
        random_total = 0;
        for (i = 0; i < PHASE_COUNT; i++) begin
            phase_ticks[i] = (phase_order[i] == SET_HIGH || phase_order[i] == SET_MAX) ?
                             LONG_PHASE_TICKS : SHORT_PHASE_TICKS;
            random_total += phase_ticks[i];
        end

        tx_idle_pct = 20;
        rx_stall_pct = 83;

        // Synchronous reset, released at a falling edge.
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].setting != SET_KEEP) load_settings(directed_rows[i].setting);
            send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);
        end

        // Idling moves through three modes over the random part: a slow receiver, then a
        // slow sender, then both sides running flat out.
        random_done = 0;
        for (i = 0; i < PHASE_COUNT; i++) begin
            load_settings(phase_order[i]);
            for (n = 0; n < phase_ticks[i]; n++) begin
                if (random_done < random_total / 3) begin
                    tx_idle_pct = 20;
                    rx_stall_pct = 83;
                end else if (random_done < 2 * random_total / 3) begin
                    tx_idle_pct = 83;
                    rx_stall_pct = 20;
                end else begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                // Now and then the sender holds off until the block has drained.
                if ($urandom_range(0, 199) == 0) wait_idle();
                send_tick(next_random_tick(), 1'b0, NO_EVENTS);
                random_done++;
            end
        end

        wait_idle();

        $display("Checked %0d results from %0d ticks across %0d register loads.",
                 results_checked, ticks_sent, settings_loaded);
        $display("Events seen: %0d short, %0d long or hold, %0d low-battery warnings.",
                 short_events, long_events, warnings);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
